/* sv/status_spinner_segment_renderer_assert.svh */
// Assertion macros shared by the status segment renderer.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef STATUS_SPINNER_SEGMENT_RENDERER_ASSERT_SVH
`define STATUS_SPINNER_SEGMENT_RENDERER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define SSR_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("status segment renderer assertion failed");

// Next-cycle implication.
`define SSR_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("status segment renderer assertion failed");

`else

`define SSR_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define SSR_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

/* sv/ssr_pkg.sv */
package ssr_pkg;

	// Segment geometry and animation timing.
	localparam int SegLeds     = 10;
	localparam int PhasePeriod = 36 * 2;
	localparam int HalfPeriod  = PhasePeriod / 2;

	// Brightness levels.
	localparam int FadeStep    = (256 / 5) - 1;
	localparam int PartialStep = 128 / 10;
	localparam int TailLevel   = 25;
	localparam int FullLevel   = 255;
	localparam int HalfLevel   = 128;

	typedef logic [7:0] level_t;
	typedef logic [3:0] idx_t;
	typedef logic [6:0] phase_t;
	typedef logic [1:0] mode_t;

	// Segment modes.
	localparam mode_t MODE_CLEAR   = 2'd0;
	localparam mode_t MODE_SPINNER = 2'd1;
	localparam mode_t MODE_FILL    = 2'd2;
	localparam mode_t MODE_SOLID   = 2'd3;

	localparam idx_t   LAST_IDX   = idx_t'(SegLeds - 1);
	localparam phase_t PHASE_LAST = phase_t'(PhasePeriod - 1);
	localparam phase_t PHASE_HALF = phase_t'(HalfPeriod);

	// Head of the spinner fades in over four quarter steps.
	function automatic level_t head_level(input logic [1:0] s);
		level_t lv;
		case (s)
			2'd0: lv = level_t'(FadeStep * 1);
			2'd1: lv = level_t'(FadeStep * 2);
			2'd2: lv = level_t'(FadeStep * 3);
			default: lv = level_t'(FadeStep * 4);
		endcase
		return lv;
	endfunction

	// Body of the spinner fades out from full brightness.
	function automatic level_t body_level(input logic [1:0] s);
		level_t lv;
		case (s)
			2'd0: lv = level_t'(FullLevel);
			2'd1: lv = level_t'(FullLevel - 1 * (FadeStep + 10));
			2'd2: lv = level_t'(FullLevel - 2 * (FadeStep + 10));
			default: lv = level_t'(FullLevel - 3 * (FadeStep + 10));
		endcase
		return lv;
	endfunction

endpackage

/* sv/status_spinner_segment_renderer.sv */
// Channel | Handshake               | Payload
// frame   | frame_valid/frame_ready | cmd, hue, percent, segment_start
// led     | led_valid/led_ready     | led_position, led_hue, led_value, last_led
//
// Each accepted frame yields ten LED words, one per cycle while led_ready does not
// stall the output; the LED word counter in the frame register sets this.
// All ten levels are computed as the frame is registered; the output register
// then takes one LED word per cycle while led_ready allows.
// The next frame is accepted in the cycle its predecessor's tenth word is loaded into the output register.
// Reset clears the frame phase and all valid flags; a stalled led_ready holds
// the output word and, behind it, the frame register.
`include "status_spinner_segment_renderer_assert.svh"

module status_spinner_segment_renderer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       frame_valid,
	output logic       frame_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] hue,
	input  logic [6:0] percent,
	input  logic [4:0] segment_start,
	output logic       led_valid,
	input  logic       led_ready,
	output logic [4:0] led_position,
	output logic [7:0] led_hue,
	output logic [7:0] led_value,
	output logic       last_led
);

	ssr_pkg::phase_t phase_q;
	ssr_pkg::phase_t phase_nx;

	logic                 valid_s1;
	ssr_pkg::idx_t        idx_q;
	ssr_pkg::level_t      lvl_s1 [ssr_pkg::SegLeds];
	logic [7:0]           hue_s1;
	logic [4:0]           start_s1;

	logic                 accept;
	logic                 load;
	logic                 s1_last;

	// Spinner and fill intermediate values.
	logic                 rising;
	logic [5:0]           sweep;
	logic [1:0]           quarter;
	ssr_pkg::idx_t        step;
	ssr_pkg::idx_t        head_pos;
	ssr_pkg::idx_t        body_pos;
	ssr_pkg::idx_t        tail_pos;
	logic                 tail_ok;
	ssr_pkg::level_t      head_lv;
	ssr_pkg::level_t      body_lv;
	ssr_pkg::level_t      tail_lv;
	logic [14:0]          pct_prod;
	logic [3:0]           full;
	logic [3:0]           pct_rem;
	ssr_pkg::level_t      partial;
	ssr_pkg::level_t      lvl_d [ssr_pkg::SegLeds];

	// Handshake control.
	assign s1_last     = (idx_q == ssr_pkg::LAST_IDX);
	assign load        = valid_s1 && (!led_valid || led_ready);
	assign frame_ready = !valid_s1 || (load && s1_last);
	assign accept      = frame_valid && frame_ready;

	// Frame phase advances before the frame is rendered.
	assign phase_nx = (phase_q == ssr_pkg::PHASE_LAST) ? '0 : phase_q + 7'd1;

	// Spinner geometry for the new phase.
	always_comb begin
		rising  = (phase_nx < ssr_pkg::PHASE_HALF);
		sweep   = rising ? phase_nx[5:0] : 6'(phase_nx - ssr_pkg::PHASE_HALF);
		quarter = sweep[1:0];
		step    = sweep[5:2];
		tail_ok = (step != 4'd0);
		if (rising) begin
			head_pos = step + 4'd1;
			body_pos = step;
			tail_pos = step - 4'd1;
		end else begin
			head_pos = 4'd8 - step;
			body_pos = 4'd9 - step;
			tail_pos = 4'd10 - step;
		end
		head_lv = ssr_pkg::head_level(quarter);
		body_lv = ssr_pkg::body_level(quarter);
		tail_lv = (quarter == 2'd0) ? ssr_pkg::level_t'(ssr_pkg::TailLevel) : '0;
	end

	// Percent split into whole LEDs and a remainder, by reciprocal multiply.
	always_comb begin
		pct_prod = 15'(percent) * 15'd205;
		full     = pct_prod[14:11];
		pct_rem  = 4'(percent - 7'(full * 4'd10));
		partial  = 8'(pct_rem * 8'(ssr_pkg::PartialStep));
	end

	// Level for each of the ten LEDs.
	always_comb begin
		for (int i = 0; i < ssr_pkg::SegLeds; i++) begin
			lvl_d[i] = '0;
			case (cmd)
				ssr_pkg::MODE_SPINNER: begin
					if (ssr_pkg::idx_t'(i) == head_pos) begin
						lvl_d[i] = head_lv;
					end else if (ssr_pkg::idx_t'(i) == body_pos) begin
						lvl_d[i] = body_lv;
					end else if (tail_ok && ssr_pkg::idx_t'(i) == tail_pos) begin
						lvl_d[i] = tail_lv;
					end
				end
				ssr_pkg::MODE_FILL: begin
					if (5'(i) <= {1'b0, full}) begin
						lvl_d[i] = ssr_pkg::level_t'(ssr_pkg::HalfLevel);
					end else if (5'(i) == {1'b0, full} + 5'd1) begin
						lvl_d[i] = partial;
					end
				end
				ssr_pkg::MODE_SOLID: begin
					lvl_d[i] = ssr_pkg::level_t'(ssr_pkg::HalfLevel);
				end
				default: begin
					lvl_d[i] = '0;
				end
			endcase
		end
	end

	// Phase and frame register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (accept) begin
				phase_q  <= phase_nx;
				valid_s1 <= 1'b1;
				idx_q    <= '0;
			end else if (load) begin
				idx_q <= idx_q + 4'd1;
				if (s1_last) begin
					valid_s1 <= 1'b0;
				end
			end
		end
	end

	// Frame payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			lvl_s1   <= lvl_d;
			hue_s1   <= hue;
			start_s1 <= segment_start;
		end
	end

	// Output word valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_valid <= 1'b0;
		end else if (load) begin
			led_valid <= 1'b1;
		end else if (led_ready) begin
			led_valid <= 1'b0;
		end
	end

	// Output word payload.
	always_ff @(posedge clk) begin
		if (load) begin
			led_position <= start_s1 + 5'(idx_q);
			led_value    <= lvl_s1[idx_q];
			led_hue      <= (lvl_s1[idx_q] != '0) ? hue_s1 : '0;
			last_led     <= s1_last;
		end
	end

	// Checks on the frame sequencing.
	`SSR_ASSERT_IMP(a_accept_only_at_end, clk, arst_n, accept && valid_s1, load && s1_last)
	`SSR_ASSERT_IMP(a_idx_in_range, clk, arst_n, valid_s1, idx_q <= ssr_pkg::LAST_IDX)
	`SSR_ASSERT_NXT(a_frame_drains, clk, arst_n, load && s1_last && !accept, !valid_s1)
	`SSR_ASSERT_NXT(a_phase_wraps, clk, arst_n, accept && phase_q == ssr_pkg::PHASE_LAST, phase_q == '0)

endmodule
